// ----- rtl/mfwl_pkg.sv -----
`timescale 1ns / 1ps
package mfwl_pkg;

   typedef struct packed {
      logic [31:0] elem_a;
      logic [31:0] elem_b;
      logic        last_element;
   } req_type;

   typedef struct packed {
      logic [31:0] elem_out;
      logic        last_out;
   } rsp_type;

   // widened operand pair as it sits in the queue
   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic        last;
   } item_type;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FORMAT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT = 2'd1;

   localparam logic [1:0] FMT_F32  = 2'd0;
   localparam logic [1:0] FMT_F16  = 2'd1;
   localparam logic [1:0] FMT_BF16 = 2'd2;

   localparam logic [31:0] WEIGHT_RESET = 32'h3F00_0000;
   localparam logic [31:0] ONE_F32      = 32'h3F80_0000;
   localparam logic [31:0] SIGN_BIT     = 32'h8000_0000;
   localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;
   localparam logic [31:0] INF_F32      = 32'h7F80_0000;
   localparam logic [31:0] DEFAULT_NAN  = 32'h7FC0_0000;

   // cycles from operands to registered result of one multiply-add unit
   localparam int unsigned FMA_LAT = 8;

   function automatic logic [5:0] msb_index(input logic [63:0] v);
      logic [5:0] pos;
      pos = 6'd0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) begin
            pos = 6'(i);
         end
      end
      return pos;
   endfunction

   function automatic logic is_nan32(input logic [31:0] v);
      return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
   endfunction

endpackage

// ----- rtl/mixed_format_weight_lerp.sv -----
`timescale 1ns / 1ps
// Blends one element pair of two weight tensors: out = a*(1-t) + b*t in fp32,
// with elements carried as fp32, fp16 or bf16 (csr register 0) and t given
// as an fp32 pattern (csr register 1, reset 0.5).
// req channel: elem_a, elem_b, last_element. rsp channel: elem_out, last_out.
// Half formats use the low 16 bits; the result's high 16 bits are zero then.
// csr channel: always ready; write only while no transfer is in flight.
// Path from req transfer to rsp_valid: the queue holds the item until the
// pipes take it, then two chained 8-stage multiply-add pipes (b*t and 1-t in
// parallel, then the final fused add), then one output register.
// Throughput: one element per cycle while the output is not stalled, set by
// the multiply-add pipes.
// Reset clears the queue, pipe valids and csr registers to their defaults.
// When rsp_ready is low with a result held the pipes freeze; the queue
// keeps taking req until full (QUEUE_DEPTH entries), then req_ready drops.
module mixed_format_weight_lerp #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  mfwl_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output mfwl_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mfwl_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [31:0]                          csr_wdata
);

   logic [1:0]         format_ff;
   logic [31:0]        weight_ff;
   logic               item_valid, item_ready;
   mfwl_pkg::item_type item_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= mfwl_pkg::FMT_F32;
         weight_ff <= mfwl_pkg::WEIGHT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            mfwl_pkg::CSR_FORMAT: format_ff <= csr_wdata[1:0];
            mfwl_pkg::CSR_WEIGHT: weight_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   mfwl_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .element_format(format_ff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .item_valid    (item_valid),
      .item_ready    (item_ready),
      .item_data     (item_data)
   );

   mfwl_back u_back (
      .clock         (clock),
      .reset         (reset),
      .element_format(format_ff),
      .blend_weight  (weight_ff),
      .item_valid    (item_valid),
      .item_ready    (item_ready),
      .item_data     (item_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data)
   );

   a_reset_quiet: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

// ----- rtl/mfwl_fifo.sv -----
`timescale 1ns / 1ps
module mfwl_fifo #(
   parameter int unsigned DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  mfwl_pkg::item_type push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output mfwl_pkg::item_type pop_data
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   mfwl_pkg::item_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          push, pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count beyond depth");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow a lone push");

endmodule

// ----- rtl/mfwl_front.sv -----
`timescale 1ns / 1ps
module mfwl_front #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         element_format,
   input  logic               req_valid,
   output logic               req_ready,
   input  mfwl_pkg::req_type  req_data,
   output logic               item_valid,
   input  logic               item_ready,
   output mfwl_pkg::item_type item_data
);

   mfwl_pkg::item_type widened;

   // exact fp16 -> fp32
   function automatic logic [31:0] widen_f16(input logic [15:0] h);
      logic       s;
      logic [4:0] e;
      logic [9:0] f;
      logic [5:0] k;
      logic [22:0] fr;
      s = h[15];
      e = h[14:10];
      f = h[9:0];
      k = mfwl_pkg::msb_index({54'd0, f});
      fr = 23'({13'd0, f} << (5'd23 - k[4:0]));
      if (e == 5'h1F) begin
         return {s, 8'hFF, f, 13'd0};
      end else if (e == 5'd0) begin
         if (f == 10'd0) begin
            return {s, 31'd0};
         end
         return {s, 8'({2'd0, k}) + 8'd103, fr};
      end
      return {s, 8'({3'd0, e}) + 8'd112, f, 13'd0};
   endfunction

   always_comb begin
      widened.last = req_data.last_element;
      case (element_format)
         mfwl_pkg::FMT_F32: begin
            widened.a = req_data.elem_a;
            widened.b = req_data.elem_b;
         end
         mfwl_pkg::FMT_F16: begin
            widened.a = widen_f16(req_data.elem_a[15:0]);
            widened.b = widen_f16(req_data.elem_b[15:0]);
         end
         default: begin
            widened.a = {req_data.elem_a[15:0], 16'd0};
            widened.b = {req_data.elem_b[15:0], 16'd0};
         end
      endcase
   end

   mfwl_fifo #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(req_valid),
      .push_ready(req_ready),
      .push_data (widened),
      .pop_valid (item_valid),
      .pop_ready (item_ready),
      .pop_data  (item_data)
   );

endmodule

// ----- rtl/mfwl_fma.sv -----
`timescale 1ns / 1ps
module mfwl_fma (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] x,
   input  logic [31:0] y,
   input  logic [31:0] z,
   output logic [31:0] result
);

   localparam logic [30:0] INF_31 = 31'h7F80_0000;

   // stage 1 inputs
   logic        sp, sz;
   logic [23:0] mx, my, mz;
   logic signed [10:0] exx, eyy, ezz;
   logic [47:0] mp_c;
   logic        xinf, yinf, zinf, xzero, yzero;
   logic        spec_c;
   logic [31:0] sval_c;

   // special results ride along the pipe
   logic        spec_ff [1:7];
   logic [31:0] sval_ff [1:7];

   logic [47:0] s1_mp_ff;
   logic signed [10:0] s1_ep_ff, s1_ez_ff;
   logic [23:0] s1_mz_ff;
   logic        s1_sp_ff, s1_sz_ff;

   logic [47:0] s2_mp_ff;
   logic [23:0] s2_mz_ff;
   logic signed [10:0] s2_ep_ff, s2_ez_ff;
   logic [5:0]  s2_sha_ff, s2_shb_ff;
   logic        s2_sp_ff, s2_sz_ff;

   logic [63:0] s3_a_ff, s3_b_ff;
   logic signed [10:0] s3_ea_ff;
   logic [5:0]  s3_d_ff;
   logic        s3_sa_ff, s3_sb_ff;

   logic [63:0] s4_a_ff, s4_b_ff;
   logic signed [10:0] s4_ea_ff;
   logic        s4_sa_ff, s4_sb_ff;

   logic [63:0] s5_s_ff;
   logic signed [10:0] s5_ea_ff;
   logic        s5_sign_ff;

   logic [63:0] s6_s_ff;
   logic signed [10:0] s6_ea_ff;
   logic [5:0]  s6_p_ff;
   logic        s6_sign_ff;

   logic [63:0] s7_s_ff;
   logic signed [10:0] s7_be_ff, s7_sh_ff;
   logic        s7_sign_ff;

   logic [31:0] result_ff;

   assign result = result_ff;

   always_comb begin
      sp = x[31] ^ y[31];
      sz = z[31];
      mx = (x[30:23] == 8'd0) ? {1'b0, x[22:0]} : {1'b1, x[22:0]};
      my = (y[30:23] == 8'd0) ? {1'b0, y[22:0]} : {1'b1, y[22:0]};
      mz = (z[30:23] == 8'd0) ? {1'b0, z[22:0]} : {1'b1, z[22:0]};
      exx = (x[30:23] == 8'd0) ? -11'sd149 : $signed({3'd0, x[30:23]}) - 11'sd150;
      eyy = (y[30:23] == 8'd0) ? -11'sd149 : $signed({3'd0, y[30:23]}) - 11'sd150;
      ezz = (z[30:23] == 8'd0) ? -11'sd149 : $signed({3'd0, z[30:23]}) - 11'sd150;
      mp_c = {24'd0, mx} * {24'd0, my};
      xinf = (x[30:0] == INF_31);
      yinf = (y[30:0] == INF_31);
      zinf = (z[30:0] == INF_31);
      xzero = (x[30:0] == 31'd0);
      yzero = (y[30:0] == 31'd0);
      spec_c = 1'b1;
      sval_c = z;
      if (mfwl_pkg::is_nan32(x)) begin
         sval_c = x | mfwl_pkg::QUIET_BIT;
      end else if (mfwl_pkg::is_nan32(y)) begin
         sval_c = y | mfwl_pkg::QUIET_BIT;
      end else if (mfwl_pkg::is_nan32(z)) begin
         sval_c = z | mfwl_pkg::QUIET_BIT;
      end else if (xinf || yinf) begin
         if (xzero || yzero || (zinf && (sz != sp))) begin
            sval_c = mfwl_pkg::DEFAULT_NAN;
         end else begin
            sval_c = {sp, INF_31};
         end
      end else if (zinf) begin
         sval_c = z;
      end else if ((mx == 24'd0 || my == 24'd0) && mz == 24'd0) begin
         sval_c = (sp == sz) ? {sp, 31'd0} : 32'd0;
      end else if (mx == 24'd0 || my == 24'd0) begin
         sval_c = z;
      end else begin
         spec_c = 1'b0;
      end
   end

   // stage 2..3 combinational
   logic [63:0] a_raw, b_raw;
   logic signed [10:0] ea_raw, eb_raw, d_full;
   logic        swap, zero_z;
   // stage 4
   logic [63:0] b_sh, b_mask;
   // stage 5
   logic [63:0] s_sum;
   logic        s_sign;
   // stage 7
   logic signed [10:0] be_c, sh_c;
   // stage 8
   logic signed [10:0] nsh;
   logic [63:0] m_c, rem, half, rmask;
   logic [5:0]  k;
   logic [35:0] bits;
   logic [31:0] packed_c;

   always_comb begin
      zero_z = (s2_mz_ff == 24'd0);
      a_raw  = {16'd0, s2_mp_ff} << s2_sha_ff;
      b_raw  = {40'd0, s2_mz_ff} << s2_shb_ff;
      ea_raw = s2_ep_ff - $signed({5'd0, s2_sha_ff});
      eb_raw = s2_ez_ff - $signed({5'd0, s2_shb_ff});
      swap   = !zero_z && (ea_raw < eb_raw);
      d_full = swap ? (eb_raw - ea_raw) : (ea_raw - eb_raw);
   end

   always_comb begin
      b_mask = (64'd1 << s3_d_ff) - 64'd1;
      if (s3_d_ff == 6'd63) begin
         b_sh = 64'd1;
      end else begin
         b_sh = (s3_b_ff >> s3_d_ff) | {63'd0, ((s3_b_ff & b_mask) != 64'd0)};
      end
   end

   always_comb begin
      if (s4_sa_ff == s4_sb_ff) begin
         s_sum  = s4_a_ff + s4_b_ff;
         s_sign = s4_sa_ff;
      end else if (s4_a_ff >= s4_b_ff) begin
         s_sum  = s4_a_ff - s4_b_ff;
         s_sign = s4_sa_ff;
      end else begin
         s_sum  = s4_b_ff - s4_a_ff;
         s_sign = s4_sb_ff;
      end
   end

   always_comb begin
      be_c = $signed({5'd0, s6_p_ff}) + s6_ea_ff + 11'sd127;
      sh_c = $signed({5'd0, s6_p_ff}) - 11'sd23;
      if (be_c < 11'sd1) begin
         sh_c = sh_c + 11'sd1 - be_c;
         be_c = 11'sd1;
      end
   end

   always_comb begin
      nsh   = -s7_sh_ff;
      k     = s7_sh_ff[5:0];
      rmask = (64'd1 << k) - 64'd1;
      rem   = s7_s_ff & rmask;
      half  = 64'd1 << (k - 6'd1);
      if (s7_sh_ff <= 11'sd0) begin
         m_c = s7_s_ff << nsh[5:0];
      end else if (s7_sh_ff >= 11'sd64) begin
         m_c = 64'd0;
      end else begin
         m_c = s7_s_ff >> k;
         if (rem > half || (rem == half && m_c[0])) begin
            m_c = m_c + 64'd1;
         end
      end
      bits = ({25'd0, 11'(s7_be_ff - 11'sd1)} << 23) + {11'd0, m_c[24:0]};
      if (bits >= 36'h0_7F80_0000) begin
         bits = 36'h0_7F80_0000;
      end
      packed_c = {s7_sign_ff, bits[30:0]};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         spec_ff[1]  <= spec_c;
         sval_ff[1]  <= sval_c;
         s1_mp_ff    <= mp_c;
         s1_ep_ff    <= exx + eyy;
         s1_ez_ff    <= ezz;
         s1_mz_ff    <= mz;
         s1_sp_ff    <= sp;
         s1_sz_ff    <= sz;

         for (int i = 2; i <= 7; i++) begin
            if (i != 5) begin
               spec_ff[i] <= spec_ff[i-1];
               sval_ff[i] <= sval_ff[i-1];
            end
         end

         s2_mp_ff  <= s1_mp_ff;
         s2_mz_ff  <= s1_mz_ff;
         s2_ep_ff  <= s1_ep_ff;
         s2_ez_ff  <= s1_ez_ff;
         s2_sha_ff <= 6'd61 - mfwl_pkg::msb_index({16'd0, s1_mp_ff});
         s2_shb_ff <= 6'd61 - mfwl_pkg::msb_index({40'd0, s1_mz_ff});
         s2_sp_ff  <= s1_sp_ff;
         s2_sz_ff  <= s1_sz_ff;

         s3_a_ff  <= swap ? b_raw : a_raw;
         s3_b_ff  <= zero_z ? 64'd0 : (swap ? a_raw : b_raw);
         s3_ea_ff <= swap ? eb_raw : ea_raw;
         s3_sa_ff <= swap ? s2_sz_ff : s2_sp_ff;
         s3_sb_ff <= swap ? s2_sp_ff : s2_sz_ff;
         if (zero_z) begin
            s3_d_ff <= 6'd0;
         end else if (d_full >= 11'sd63) begin
            s3_d_ff <= 6'd63;
         end else begin
            s3_d_ff <= d_full[5:0];
         end

         s4_a_ff  <= s3_a_ff;
         s4_b_ff  <= b_sh;
         s4_ea_ff <= s3_ea_ff;
         s4_sa_ff <= s3_sa_ff;
         s4_sb_ff <= s3_sb_ff;

         // exact cancellation gives +0
         spec_ff[5] <= spec_ff[4] || (s_sum == 64'd0);
         sval_ff[5] <= spec_ff[4] ? sval_ff[4] : 32'd0;
         s5_s_ff    <= s_sum;
         s5_ea_ff   <= s4_ea_ff;
         s5_sign_ff <= s_sign;

         s6_s_ff    <= s5_s_ff;
         s6_ea_ff   <= s5_ea_ff;
         s6_p_ff    <= mfwl_pkg::msb_index(s5_s_ff);
         s6_sign_ff <= s5_sign_ff;

         s7_s_ff    <= s6_s_ff;
         s7_be_ff   <= be_c;
         s7_sh_ff   <= sh_c;
         s7_sign_ff <= s6_sign_ff;

         result_ff <= spec_ff[7] ? sval_ff[7] : packed_c;
      end
   end

endmodule

// ----- rtl/mfwl_back.sv -----
`timescale 1ns / 1ps
module mfwl_back (
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         element_format,
   input  logic [31:0]        blend_weight,
   input  logic               item_valid,
   output logic               item_ready,
   input  mfwl_pkg::item_type item_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output mfwl_pkg::rsp_type  rsp_data
);

   localparam int unsigned LAT   = mfwl_pkg::FMA_LAT;
   localparam int unsigned DEPTH = 2 * LAT;

   logic              en, pop;
   logic              vld_ff [DEPTH];
   logic [31:0]       a_dly_ff [LAT];
   logic              last_dly_ff [DEPTH];
   logic [31:0]       prod, omt_raw, omt, blend;
   logic              out_valid_ff;
   mfwl_pkg::rsp_type out_ff;

   assign en         = !out_valid_ff || rsp_ready;
   assign pop        = en && item_valid;
   assign item_ready = en;
   assign rsp_valid  = out_valid_ff;
   assign rsp_data   = out_ff;

   // fp32 -> fp16: RNE on normals, truncation on subnormals
   function automatic logic [15:0] narrow_f16(input logic [31:0] v);
      logic        s;
      logic [7:0]  ex;
      logic [22:0] frac;
      logic signed [9:0] ne, ne1, rsh;
      logic [9:0]  nf;
      logic [10:0] nf1;
      logic        rnd;
      s    = v[31];
      ex   = v[30:23];
      frac = v[22:0];
      ne   = $signed({2'd0, ex}) - 10'sd112;
      ne1  = ne + 10'sd1;
      rsh  = 10'sd1 - ne;
      nf   = frac[22:13];
      rnd  = frac[12] && ((frac[11:0] != 12'd0) || nf[0]);
      nf1  = {1'b0, nf} + {10'd0, rnd};
      if (ex == 8'hFF) begin
         return {s, 5'h1F, (frac != 23'd0), 9'd0};
      end
      if (ne <= 10'sd0) begin
         if (ne < -10'sd10) begin
            return {s, 15'd0};
         end
         return {s, 5'd0, 10'({1'b1, nf} >> rsh[3:0])};
      end
      if (ne >= 10'sd31) begin
         return {s, 5'h1F, 10'd0};
      end
      if (nf1[10]) begin
         if (ne1 >= 10'sd31) begin
            return {s, 5'h1F, 10'd0};
         end
         return {s, ne1[4:0], 10'd0};
      end
      return {s, ne[4:0], nf1[9:0]};
   endfunction

   mfwl_fma u_prod (
      .clock (clock),
      .en    (en),
      .x     (item_data.b),
      .y     (blend_weight),
      .z     (mfwl_pkg::SIGN_BIT),
      .result(prod)
   );

   mfwl_fma u_omt (
      .clock (clock),
      .en    (en),
      .x     (mfwl_pkg::ONE_F32),
      .y     (mfwl_pkg::ONE_F32),
      .z     (blend_weight ^ mfwl_pkg::SIGN_BIT),
      .result(omt_raw)
   );

   // user must hold weight static while items are in flight; not enforced here. The NaN pass uses it directly
   assign omt = mfwl_pkg::is_nan32(blend_weight) ? (blend_weight | mfwl_pkg::QUIET_BIT)
                                                 : omt_raw;

   mfwl_fma u_blend (
      .clock (clock),
      .en    (en),
      .x     (a_dly_ff[LAT-1]),
      .y     (omt),
      .z     (prod),
      .result(blend)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            vld_ff[i] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= pop;
         for (int i = 1; i < DEPTH; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
         out_valid_ff <= vld_ff[DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_dly_ff[0]    <= item_data.a;
         last_dly_ff[0] <= item_data.last;
         for (int i = 1; i < LAT; i++) begin
            a_dly_ff[i] <= a_dly_ff[i-1];
         end
         for (int i = 1; i < DEPTH; i++) begin
            last_dly_ff[i] <= last_dly_ff[i-1];
         end
         out_ff.last_out <= last_dly_ff[DEPTH-1];
         case (element_format)
            mfwl_pkg::FMT_F32: out_ff.elem_out <= blend;
            mfwl_pkg::FMT_F16: out_ff.elem_out <= {16'd0, narrow_f16(blend)};
            default:           out_ff.elem_out <= {16'd0, blend[31:16]};
         endcase
      end
   end

   a_tail_hold: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[DEPTH-1] && !en) |=> vld_ff[DEPTH-1])
      else $error("result lost in pipe while stalled");

   a_pop_gated: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !pop)
      else $error("queue popped while output stalled");

endmodule
